// ===== rtl/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants of the servo command frame parser
// Request structs for both channels, the job record passed from the parser
// front to the result back, and the fixed protocol codes.
// ----------------------------------------------------------------------------
package scp_pkg;

  // Frame protocol bytes and command codes
  localparam logic [7:0] HDR_BYTE    = 8'hFE;
  localparam logic [7:0] END_BYTE    = 8'hFA;
  localparam logic [7:0] CMD_SET_ALL = 8'h22;
  localparam logic [7:0] CMD_SET_ONE = 8'h21;
  localparam logic [7:0] CMD_READ    = 8'h20;

  localparam logic signed [15:0] NO_CHANGE = 16'sh7FFF;
  localparam logic [16:0]        MS_MAX    = 17'h1FFFF;

  // Configuration register indexes and reset values
  localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_POWER_ON = 2'd1;
  localparam logic [1:0] CFG_TORQUE   = 2'd2;

  localparam logic [15:0] TIMEOUT_RST  = 16'd3000;
  localparam logic [7:0]  POWER_ON_RST = 8'd16;
  localparam logic [7:0]  TORQUE_RST   = 8'd87;

  // Result kinds
  localparam logic [1:0] KIND_ANGLE   = 2'd0;
  localparam logic [1:0] KIND_STATUS  = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // Job codes handed from front to back
  localparam logic [1:0] JOB_STATUS  = 2'd0;
  localparam logic [1:0] JOB_RELEASE = 2'd1;
  localparam logic [1:0] JOB_ALL     = 2'd2;
  localparam logic [1:0] JOB_ONE     = 2'd3;

  // Depth of the job queue between front and back
  localparam int unsigned JOBQ_DEPTH = 4;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } scp_in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [4:0]        servo_index;
    logic signed [15:0] angle;
    logic              servo_en;
    logic              host_control;
    logic              last;
  } scp_out_t;

  typedef struct packed {
    logic [1:0]         code;
    logic [4:0]         last_idx;
    logic [4:0]         sel_idx;
    logic signed [15:0] angle;
    logic               enabled;
    logic               held;
  } scp_job_t;

endpackage

// ===== rtl/scp_ram.sv =====
// ----------------------------------------------------------------------------
// scp_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module scp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/scp_queue.sv =====
// ----------------------------------------------------------------------------
// scp_queue: short job queue between parser front and result back
// Circular buffer of job records with full and empty flags.
// ----------------------------------------------------------------------------
module scp_queue
  import scp_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  scp_job_t push_data,
  output logic     full,
  input  logic     pop,
  output scp_job_t pop_data,
  output logic     empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  scp_job_t         slot_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = slot_r[rptr_r];

  // Pointer and fill count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Slot storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/scp_front.sv =====
// ----------------------------------------------------------------------------
// scp_front: request intake, frame parsing and command classification
// Holds configuration, parser state, control timer and enable flag. Writes
// parameter bytes into the even/odd stores and queues one job per request
// that produces results.
// ----------------------------------------------------------------------------
module scp_front
  import scp_pkg::*;
#(
  parameter int unsigned SERVO_COUNT = 18,
  parameter int unsigned MAX_PARAMS  = 64,
  parameter int unsigned AW          = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  // request channel
  input  logic          in_valid,
  output logic          in_ready,
  input  scp_in_t       in_data,
  // configuration
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  // parameter store write
  output logic          wr_even,
  output logic          wr_odd,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  // job queue
  output logic          push,
  output scp_job_t      push_data,
  input  logic          q_full,
  input  logic          back_busy
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HDR1 = 2'd1;
  localparam logic [1:0] PH_HDR2 = 2'd2;
  localparam logic [1:0] PH_BODY = 2'd3;

  logic [15:0] timeout_r;
  logic [7:0]  power_code_r, torque_code_r;

  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  bc_r, bc_nxt;
  logic        held_r, held_nxt;
  logic [16:0] ms_r, ms_nxt;
  logic        en_r, en_nxt;
  // copies of the first three parameter bytes for set-single
  logic [7:0]  p0_r, p1_r, p2_r;

  logic        accept;
  logic [7:0]  b;
  logic [7:0]  widx;
  logic        store_wr;
  logic [16:0] ms_inc;
  logic [7:0]  half_len;
  logic [7:0]  all_cnt;

  assign cfg_ready = 1'b1;

  // Stall store-writing bytes while earlier jobs may still read the store
  assign in_ready = !q_full && !((phase_r == PH_BODY) && (bc_r != '0) && back_busy);
  assign accept   = in_valid && in_ready;
  assign b        = in_data.rx_byte;
  assign widx     = bc_r - 8'd1;

  assign ms_inc   = (ms_r < MS_MAX) ? ms_r + 17'd1 : ms_r;
  assign half_len = (len_r >= 8'd1) ? ((len_r - 8'd1) >> 1) : 8'd0;
  assign all_cnt  = (half_len > 8'(SERVO_COUNT)) ? 8'(SERVO_COUNT) : half_len;

  // Parameter store write port
  assign store_wr = accept && !in_data.req_type && (phase_r == PH_BODY)
                    && (bc_r != '0) && (widx < 8'(MAX_PARAMS));
  assign wr_even  = store_wr && !widx[0];
  assign wr_odd   = store_wr && widx[0];
  assign wr_addr  = AW'(widx[7:1]);
  assign wr_data  = b;

  // Parse, dispatch and timer logic
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    bc_nxt    = bc_r;
    held_nxt  = held_r;
    ms_nxt    = ms_r;
    en_nxt    = en_r;
    push      = 1'b0;
    push_data = '0;
    if (accept) begin
      if (in_data.req_type) begin
        // millisecond tick
        ms_nxt = ms_inc;
        if (held_r && (ms_inc > {1'b0, timeout_r})) begin
          held_nxt       = 1'b0;
          push           = 1'b1;
          push_data.code = JOB_RELEASE;
        end
      end else if ((b == END_BYTE) && (phase_r == PH_IDLE)) begin
        // dispatch the stored command
        ms_nxt         = '0;
        held_nxt       = 1'b1;
        push           = 1'b1;
        push_data.code = JOB_STATUS;
        priority if (cmd_r == power_code_r) begin
          en_nxt = 1'b1;
        end else if (cmd_r == CMD_SET_ALL) begin
          if (all_cnt != '0) begin
            push_data.code     = JOB_ALL;
            push_data.last_idx = 5'(all_cnt - 8'd1);
          end
        end else if (cmd_r == CMD_SET_ONE) begin
          if ((len_r >= 8'd4) && (p0_r < 8'(SERVO_COUNT))) begin
            push_data.code     = JOB_ONE;
            push_data.last_idx = 5'(SERVO_COUNT - 1);
            push_data.sel_idx  = p0_r[4:0];
            push_data.angle    = $signed({p1_r, p2_r});
          end
        end else if (cmd_r == CMD_READ) begin
          en_nxt = en_r;
        end else if (cmd_r == torque_code_r) begin
          if (len_r >= 8'd2) begin
            en_nxt = 1'b1;
          end
        end else begin
          en_nxt = en_r;
        end
      end else begin
        // frame parser
        unique case (phase_r)
          PH_IDLE: begin
            if (b == HDR_BYTE) begin
              phase_nxt = PH_HDR1;
            end
          end
          PH_HDR1: begin
            phase_nxt = (b == HDR_BYTE) ? PH_HDR2 : PH_IDLE;
          end
          PH_HDR2: begin
            len_nxt   = b;
            cmd_nxt   = '0;
            bc_nxt    = '0;
            phase_nxt = ((b >= 8'd1) && (b <= 8'(MAX_PARAMS + 1))) ? PH_BODY : PH_IDLE;
          end
          default: begin
            if (bc_r == '0) begin
              cmd_nxt = b;
            end
            bc_nxt = bc_r + 8'd1;
            if ((bc_r + 8'd1) >= len_r) begin
              phase_nxt = PH_IDLE;
            end
          end
        endcase
      end
    end
    push_data.enabled = en_nxt;
    push_data.held    = held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= TIMEOUT_RST;
      power_code_r  <= POWER_ON_RST;
      torque_code_r <= TORQUE_RST;
      phase_r       <= PH_IDLE;
      len_r         <= '0;
      cmd_r         <= '0;
      bc_r          <= '0;
      held_r        <= 1'b0;
      ms_r          <= '0;
      en_r          <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cmd_r   <= cmd_nxt;
      bc_r    <= bc_nxt;
      held_r  <= held_nxt;
      ms_r    <= ms_nxt;
      en_r    <= en_nxt;
      // configuration writes; index 3 is ignored
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_TIMEOUT:  timeout_r     <= cfg_data;
          CFG_POWER_ON: power_code_r  <= cfg_data[7:0];
          CFG_TORQUE:   torque_code_r <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // Copies of parameters 0..2, no reset
  always_ff @(posedge clk) begin
    if (store_wr) begin
      if (widx == 8'd0) p0_r <= b;
      if (widx == 8'd1) p1_r <= b;
      if (widx == 8'd2) p2_r <= b;
    end
  end

endmodule

// ===== rtl/scp_back.sv =====
// ----------------------------------------------------------------------------
// scp_back: result generation
// Pops one job at a time and emits its results through an output register,
// reading angle pairs from the even/odd parameter stores for set-all.
// ----------------------------------------------------------------------------
module scp_back
  import scp_pkg::*;
#(
  parameter int unsigned AW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  // job queue
  input  logic          q_empty,
  input  scp_job_t      q_data,
  output logic          pop,
  output logic          busy,
  // parameter store read
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_even,
  input  logic [7:0]    rd_odd,
  // result channel
  output logic          out_valid,
  input  logic          out_ready,
  output scp_out_t      out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [4:0] idx_r, idx_nxt;
  scp_job_t   job_r, job_nxt;
  scp_out_t   out_r, out_nxt;
  logic       is_last;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = out_r;
  assign is_last   = (idx_r == job_r.last_idx);
  // read data arrives in the cycle after the address, in time for the load
  assign rd_addr   = AW'(idx_nxt);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    job_nxt   = job_r;
    out_nxt   = out_r;
    pop       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          job_nxt   = q_data;
          idx_nxt   = '0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // build one result in the output register
        out_nxt.servo_index  = '0;
        out_nxt.angle        = '0;
        out_nxt.servo_en     = job_r.enabled;
        out_nxt.host_control = job_r.held;
        out_nxt.last         = is_last;
        unique case (job_r.code)
          JOB_ALL: begin
            out_nxt.kind        = KIND_ANGLE;
            out_nxt.servo_index = idx_r;
            out_nxt.angle       = $signed({rd_even, rd_odd});
          end
          JOB_ONE: begin
            out_nxt.kind        = KIND_ANGLE;
            out_nxt.servo_index = idx_r;
            out_nxt.angle       = (idx_r == job_r.sel_idx) ? job_r.angle : NO_CHANGE;
          end
          JOB_RELEASE: out_nxt.kind = KIND_RELEASE;
          default:     out_nxt.kind = KIND_STATUS;
        endcase
        state_nxt = ST_OUT;
      end
      default: begin
        if (out_ready) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 5'd1;
            state_nxt = ST_LOAD;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    out_r <= out_nxt;
  end

endmodule

// ===== rtl/servo_command_frame_parser.sv =====
// ----------------------------------------------------------------------------
// servo_command_frame_parser: serial servo command frame parser
// Parses header/length/command/parameter frames and turns dispatched
// commands and control timeouts into servo angle and status results.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per handshake, either a received byte or a 1 ms tick.
//   out_* : result requests; the final one caused by a request has last set.
//   cfg_* : register writes (timeout, power-on code, torque-on code), always
//           ready; write only while the block is idle.
// Timing:
//   Requests are taken one per cycle while the job queue has room. Bytes
//   that write the parameter store are held off while earlier results are
//   still being produced, since those read the same store.
//   The first result is presented once its request has been queued, popped
//   and loaded into the output register; each further result of the same
//   request is loaded after the previous one is taken and then presented,
//   so results are never presented back to back.
// Reset (rst_n low, synchronous): parser idle, control released, servos
//   disabled, registers at their defaults, queue empty. The parameter store
//   is not cleared. A stalled result holds in the output register while the
//   front keeps taking requests until the queue fills or a parameter byte is due.
// ----------------------------------------------------------------------------
module servo_command_frame_parser
  import scp_pkg::*;
#(
  parameter int unsigned SERVO_COUNT = 18,
  parameter int unsigned MAX_PARAMS  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  scp_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output scp_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned HALF = (MAX_PARAMS + 1) / 2;
  localparam int unsigned AW   = $clog2(HALF);

  logic          wr_even, wr_odd;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_even, rd_odd;
  logic          push, pop, q_full, q_empty;
  logic          back_busy, busy;
  scp_job_t      push_data, pop_data;

  assign back_busy = busy || !q_empty;

  scp_front #(
    .SERVO_COUNT (SERVO_COUNT),
    .MAX_PARAMS  (MAX_PARAMS),
    .AW          (AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr_even   (wr_even),
    .wr_odd    (wr_odd),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full),
    .back_busy (back_busy)
  );

  // Even and odd parameter bytes, so one read gives a whole angle
  scp_ram #(.WIDTH(8), .DEPTH(HALF)) u_ram_even (
    .clk     (clk),
    .wr_en   (wr_even),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_even)
  );

  scp_ram #(.WIDTH(8), .DEPTH(HALF)) u_ram_odd (
    .clk     (clk),
    .wr_en   (wr_odd),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_odd)
  );

  scp_queue #(.DEPTH(JOBQ_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  scp_back #(.AW(AW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .busy      (busy),
    .rd_addr   (rd_addr),
    .rd_even   (rd_even),
    .rd_odd    (rd_odd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
